// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the stepper position sequencer RTL.
// Expect clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SPS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sps assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define SPS_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sps assertion failed: next-cycle implication");

`endif

// ===== rtl/sps_pkg.sv =====
// Types and constants of the stepper position sequencer.
// No dependencies; used by the interfaces and every module.
package sps_pkg;

  localparam int PADDR_W = 3;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_ABS   = 3'd1;
  localparam logic [2:0] FUNC_RUN   = 3'd2;
  localparam logic [2:0] FUNC_REL   = 3'd3;
  localparam logic [2:0] FUNC_RESET = 3'd4;

  localparam logic [1:0] DIR_UP   = 2'd2;
  localparam logic [1:0] DIR_DOWN = 2'd0;

  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic        REG_PERIOD   = 1'b0;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] speed;
    logic [1:0]  direction;
    logic [31:0] distance_or_target;
  } in_item_t;

  typedef struct packed {
    logic        pwm_on;
    logic [15:0] counter_load;
    logic [15:0] compare_value;
    logic        dir_level;
    logic [31:0] position;
    logic        move_done;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic [31:0] cur_position;
    logic [31:0] steps_taken;
    logic [31:0] steps_wanted;
    logic [15:0] run_speed;
    logic [1:0]  run_dir;
    logic        running;
    logic        pin_level;
  } motor_state_t;

endpackage

// ===== rtl/sps_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on sps_pkg for the payload types.
interface sps_cmd_if;
  logic               valid;
  logic               ready;
  sps_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sps_res_if;
  logic               valid;
  logic               ready;
  sps_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sps_apb_regs.sv =====
// APB configuration register file: holds period_limit.
// Depends on sps_pkg.
module sps_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [15:0]                 period_limit
);
  import sps_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_limit <= PERIOD_RESET;
    end else if (wr_en) begin
      period_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PERIOD) begin
      prdata = {16'd0, period_limit};
    end
  end
endmodule

// ===== rtl/sps_core.sv =====
// Motor state registers and the single-pass update for one item.
// Depends on sps_pkg.
module sps_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sps_pkg::in_item_t   item,
  input  logic [15:0]         period_limit,
  output sps_pkg::out_item_t  result
);
  import sps_pkg::*;

  motor_state_t st;
  motor_state_t st_next;
  logic [31:0]  diff;
  logic         diff_pos;
  logic [15:0]  spd_clamped;

  assign diff        = item.distance_or_target - st.cur_position;
  assign diff_pos    = (diff != 32'd0) && !diff[31];
  assign spd_clamped = (item.speed > period_limit) ? period_limit : item.speed;

  always_comb begin
    st_next              = st;
    result               = '0;
    unique case (item.func)
      FUNC_TICK: begin
        if (st.running) begin
          if (st.steps_taken == st.steps_wanted) begin
            st_next.steps_taken  = '0;
            st_next.steps_wanted = '0;
            st_next.running      = 1'b0;
            result.move_done     = 1'b1;
          end else begin
            result.pwm_on        = 1'b1;
            result.counter_load  = period_limit + st.run_speed;
            result.compare_value = period_limit - st.run_speed;
            if (st.run_dir == DIR_UP) begin
              st_next.pin_level    = 1'b1;
              st_next.cur_position = st.cur_position + 32'd1;
            end else if (st.run_dir == DIR_DOWN) begin
              st_next.pin_level    = 1'b0;
              st_next.cur_position = st.cur_position - 32'd1;
            end
            st_next.steps_taken = st.steps_taken + 32'd1;
          end
        end
      end
      FUNC_ABS: begin
        st_next.run_speed    = spd_clamped;
        st_next.run_dir      = diff_pos ? DIR_UP : DIR_DOWN;
        st_next.steps_wanted = diff_pos ? diff : (32'd0 - diff);
        st_next.steps_taken  = '0;
        st_next.running      = 1'b1;
      end
      FUNC_RUN: begin
        st_next.run_speed    = item.speed;
        st_next.run_dir      = item.direction;
        st_next.steps_wanted = ALL_ONES;
        st_next.running      = 1'b1;
      end
      FUNC_REL: begin
        st_next.run_speed    = spd_clamped;
        st_next.run_dir      = item.direction;
        st_next.steps_wanted = item.distance_or_target;
        st_next.steps_taken  = '0;
        st_next.running      = 1'b1;
      end
      FUNC_RESET: begin
        st_next           = '0;
        st_next.pin_level = st.pin_level;
      end
      default: begin
      end
    endcase
    result.dir_level = st_next.pin_level;
    result.position  = st_next.cur_position;
    result.busy_res  = st_next.running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end
endmodule

// ===== rtl/stepper_position_sequencer_unit.sv =====
// Stepper position sequencer: step/direction motor control per command item.
// Channels: cmd (sink) takes tick and command items, res (source) gives one
// result per item, both valid/ready; a transfer happens when both are high.
// An APB port writes period_limit at byte address 0 (reset value 100).
// Path: a command item lands in the input register, and its result is then
// captured in the result register, which drives res.valid.
// Throughput: one item per cycle while res takes results; the motor state
// update is a single compare/add pass between the two registers.
// Stall: while res is held off, the result register holds and the input
// register still takes one more item; cmd.ready drops only when both are full.
// Reset (rst, synchronous): clears position, counts, speed, direction,
// the run flag and the pin level, empties both registers and restores
// period_limit to 100.
// Depends on sps_pkg, sps_if, sps_apb_regs, sps_core, assert_macros.svh.
`include "assert_macros.svh"

module stepper_position_sequencer_unit (
  input  logic                        clk,
  input  logic                        rst,
  sps_cmd_if.sink                     cmd,
  sps_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sps_pkg::*;

  logic        in_valid;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  out_item_t   result;
  logic        out_adv;
  logic        in_adv;
  logic [15:0] period_limit;

  assign out_adv   = !out_valid || res.ready;
  assign in_adv    = in_valid && out_adv;
  assign cmd.ready = !in_valid || out_adv;

  assign res.valid   = out_valid;
  assign res.payload = out_item;

  sps_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .period_limit (period_limit)
  );

  sps_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (in_adv),
    .item         (in_item),
    .period_limit (period_limit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_item <= result;
    end
  end

  `SPS_ASSERT_NXT(a_cmd_lands, cmd.valid && cmd.ready, in_valid)
  `SPS_ASSERT_IMP(a_done_stops, out_valid && out_item.move_done, !out_item.busy_res)
  `SPS_ASSERT_IMP(a_pulse_running, out_valid && out_item.pwm_on,
                  out_item.busy_res && !out_item.move_done)
  `SPS_ASSERT_IMP(a_idle_timer, out_valid && !out_item.pwm_on,
                  out_item.counter_load == 16'd0 && out_item.compare_value == 16'd0)
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stepper_position_sequencer_unit: moves, runs, ticks and resets
// over several period_limit settings, checked against an in-bench motor predictor.
// Depends on sps_pkg, sps_if and the unit's RTL.
module tb_top;
  import sps_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          PHASE_ITEMS   = 240;
  localparam logic [1:0]  DIR_HOLD_LO   = 2'd1;
  localparam logic [1:0]  DIR_HOLD_HI   = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sps_cmd_if cmd_ch ();
  sps_res_if res_ch ();

  stepper_position_sequencer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  motor_state_t motor;
  logic [15:0]  period_setting;
  in_item_t     cmd_backlog[$];
  out_item_t    step_reports[$];

  int  planned_items;
  int  send_gap;
  int  recv_gap;
  bit  send_calm;
  bit  recv_calm;
  int  mismatches;
  int  results_seen;
  int  pulses_seen;
  int  moves_finished;
  int  settings_used;
  int  cycle_count;
  out_item_t wanted_report;

  function automatic out_item_t step_motor(in_item_t it);
    out_item_t   r;
    logic [31:0] gap;
    logic [15:0] capped;
    logic        pin_keep;
    r = '0;
    capped = (it.speed > period_setting) ? period_setting : it.speed;
    case (it.func)
      FUNC_TICK: begin
        if (motor.running) begin
          if (motor.steps_taken == motor.steps_wanted) begin
            motor.steps_taken  = '0;
            motor.steps_wanted = '0;
            motor.running      = 1'b0;
            r.move_done        = 1'b1;
          end else begin
            r.pwm_on        = 1'b1;
            r.counter_load  = period_setting + motor.run_speed;
            r.compare_value = period_setting - motor.run_speed;
            if (motor.run_dir == DIR_UP) begin
              motor.pin_level    = 1'b1;
              motor.cur_position = motor.cur_position + 32'd1;
            end else if (motor.run_dir == DIR_DOWN) begin
              motor.pin_level    = 1'b0;
              motor.cur_position = motor.cur_position - 32'd1;
            end
            motor.steps_taken = motor.steps_taken + 32'd1;
          end
        end
      end
      FUNC_ABS: begin
        gap = it.distance_or_target - motor.cur_position;
        motor.run_speed   = capped;
        motor.steps_taken = '0;
        motor.running     = 1'b1;
        if (gap != 32'd0 && !gap[31]) begin
          motor.run_dir      = DIR_UP;
          motor.steps_wanted = gap;
        end else begin
          motor.run_dir      = DIR_DOWN;
          motor.steps_wanted = 32'd0 - gap;
        end
      end
      FUNC_RUN: begin
        motor.run_speed    = it.speed;
        motor.run_dir      = it.direction;
        motor.steps_wanted = ALL_ONES;
        motor.running      = 1'b1;
      end
      FUNC_REL: begin
        motor.run_speed    = capped;
        motor.run_dir      = it.direction;
        motor.steps_wanted = it.distance_or_target;
        motor.steps_taken  = '0;
        motor.running      = 1'b1;
      end
      FUNC_RESET: begin
        pin_keep        = motor.pin_level;
        motor           = '0;
        motor.pin_level = pin_keep;
      end
      default: begin
      end
    endcase
    r.dir_level = motor.pin_level;
    r.position  = motor.cur_position;
    r.busy_res  = motor.running;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sender: hold the payload until the transfer, then idle for a random gap.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        step_reports.push_back(step_motor(cmd_ch.payload));
      end
      if (cmd_ch.valid && !cmd_ch.ready) begin
      end else if (send_gap != 0) begin
        send_gap = send_gap - 1;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cmd_ch.payload <= cmd_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_gap();
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (res_ch.payload.pwm_on) pulses_seen++;
        if (res_ch.payload.move_done) moves_finished++;
        if (step_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing pending: %p", $realtime, res_ch.payload);
        end else begin
          wanted_report = step_reports.pop_front();
          if (res_ch.payload !== wanted_report) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, results_seen);
              $display("  expected: pwm %b load %h cmp %h dir %b pos %h done %b busy %b",
                wanted_report.pwm_on, wanted_report.counter_load,
                wanted_report.compare_value, wanted_report.dir_level,
                wanted_report.position, wanted_report.move_done, wanted_report.busy_res);
              $display("  actual:   pwm %b load %h cmp %h dir %b pos %h done %b busy %b",
                res_ch.payload.pwm_on, res_ch.payload.counter_load,
                res_ch.payload.compare_value, res_ch.payload.dir_level,
                res_ch.payload.position, res_ch.payload.move_done,
                res_ch.payload.busy_res);
            end
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
        step_reports.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] f, logic [15:0] s, logic [1:0] d, logic [31:0] t);
    in_item_t it;
    it.func               = f;
    it.speed              = s;
    it.direction          = d;
    it.distance_or_target = t;
    cmd_backlog.push_back(it);
    if (f <= FUNC_RESET) planned_items++;
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) queue_item(FUNC_TICK, 16'($urandom), 2'($urandom), $urandom);
  endtask

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, period_setting));
      1: return 16'hffff;
      2: return period_setting;
      3: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Ticks to finish a move of n steps; moves over 20 steps, and now and then shorter ones, are cut short.
  function automatic int ticks_for(logic [31:0] n);
    if (n > 32'd20) return $urandom_range(1, 10);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, n);
    return n + 1 + $urandom_range(0, 2);
  endfunction

  task automatic queue_sequence();
    int          offs;
    logic [31:0] span;
    logic [31:0] aim;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        span = ($urandom_range(0, 9) == 0) ? $urandom :
               ($urandom_range(0, 9) == 0) ? ALL_ONES : $urandom_range(0, 12);
        queue_item(FUNC_REL, pick_speed(), 2'($urandom), span);
        queue_ticks(ticks_for(span));
      end
      3, 4, 5: begin
        offs = $urandom_range(0, 24) - 12;
        aim  = motor.cur_position + 32'(offs);
        span = (offs < 0) ? -offs : offs;
        if ($urandom_range(0, 7) == 0) begin
          aim  = $urandom;
          span = ALL_ONES;
        end else if ($urandom_range(0, 15) == 0) begin
          aim  = motor.cur_position ^ 32'h8000_0000;
          span = ALL_ONES;
        end
        queue_item(FUNC_ABS, pick_speed(), 2'($urandom), aim);
        queue_ticks(ticks_for(span));
      end
      6, 7: begin
        queue_item(FUNC_RUN, pick_speed(), 2'($urandom), $urandom);
        queue_ticks($urandom_range(1, 15));
        if ($urandom_range(0, 1) == 0)
          queue_item(FUNC_RESET, 16'($urandom), 2'($urandom), $urandom);
      end
      8: begin
        queue_item(FUNC_RESET, 16'($urandom), 2'($urandom), $urandom);
        queue_ticks($urandom_range(0, 3));
      end
      default: begin
        for (int i = $urandom_range(1, 3); i > 0; i--)
          queue_item(3'($urandom_range(0, 7)), 16'($urandom), 2'($urandom), $urandom);
      end
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || step_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int n);
    int goal;
    goal = planned_items + n;
    while (planned_items < goal) begin
      @(negedge clk);
      while (cmd_backlog.size() > 1) @(negedge clk);
      queue_sequence();
    end
    wait_drained();
  endtask

  task automatic write_period(logic [15:0] value);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PERIOD, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    period_setting = value;
    settings_used++;
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    res_ch.ready   = 1'b0;
    motor          = '0;
    period_setting = PERIOD_RESET;
    settings_used  = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_item(FUNC_TICK, 16'hffff, DIR_HOLD_HI, ALL_ONES);
    queue_item(FUNC_ABS, 16'd40, DIR_UP, 32'd0);
    queue_ticks(1);
    queue_item(FUNC_REL, 16'hffff, DIR_UP, 32'd3);
    queue_ticks(4);
    queue_item(FUNC_REL, 16'd50, DIR_HOLD_LO, 32'd2);
    queue_ticks(3);
    queue_item(FUNC_REL, 16'd0, DIR_HOLD_HI, 32'd0);
    queue_ticks(1);
    queue_item(FUNC_RESET, 16'hffff, DIR_HOLD_HI, ALL_ONES);
    queue_item(FUNC_REL, 16'd100, DIR_DOWN, 32'd1);
    queue_ticks(2);
    queue_item(FUNC_RUN, 16'hffff, DIR_UP, 32'd0);
    queue_ticks(2);
    for (int f = FUNC_RESET + 1; f < 8; f++)
      queue_item(3'(f), 16'hffff, DIR_HOLD_HI, ALL_ONES);
    queue_item(FUNC_ABS, 16'hffff, DIR_HOLD_LO, 32'h8000_0001);
    queue_ticks(1);
    queue_item(FUNC_ABS, 16'd0, DIR_UP, ALL_ONES);
    queue_item(FUNC_RESET, 16'd0, DIR_DOWN, 32'd0);
    wait_drained();

    run_phase(PHASE_ITEMS);
    write_period(16'hffff);
    run_phase(PHASE_ITEMS);
    write_period(16'h0000);
    run_phase(PHASE_ITEMS);
    write_period(16'($urandom));
    run_phase(PHASE_ITEMS);
    write_period(16'd7);
    run_phase(PHASE_ITEMS);

    wait_drained();
    repeat (4) @(posedge clk);
    if (step_reports.size() != 0) mismatches++;
    $display("Covered %0d transfers over %0d period settings: %0d step pulses, %0d moves done.",
      results_seen, settings_used, pulses_seen, moves_finished);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
